// File: rtl/quadratic_root_solver_assert.svh
// Assertion macros shared by the quadratic root solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH
// Consequent must hold in the same cycle as the antecedent.
`define QRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// Condition must never be seen.
`define QRS_NEVER(lbl, cond, msg) \
  `QRS_ASSERT_SAME(lbl, 1'b1, !(cond), msg)
`endif

// File: rtl/qrs_pkg.sv
// Shared widths, case codes and item types for the quadratic root solver.
package qrs_pkg;

  localparam int COEF_W   = 16;
  localparam int ROOT_W   = 32;
  localparam int FRAC_IN  = 8;
  localparam int FRAC_OUT = 16;

  localparam int DISC_W  = 2*COEF_W + 4;
  localparam int MAG_W   = 2*COEF_W + 1;
  localparam int SQ_W    = (MAG_W + FRAC_OUT + 1) / 2;
  localparam int SQ_IN_W = 2*SQ_W;
  localparam int NB_W    = COEF_W + FRAC_IN + 1;
  localparam int NUM_W   = ((NB_W > SQ_W + 1) ? NB_W : SQ_W + 1) + 1;
  localparam int DEN_W   = COEF_W + 2;
  localparam int DVS_W   = COEF_W + 1;
  localparam int DVD_W   = NUM_W + FRAC_IN;
  localparam int QUO_W   = DVD_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  typedef logic [2:0] kind_t;

  localparam kind_t CASE_TWO     = 3'd0;
  localparam kind_t CASE_DOUBLE  = 3'd1;
  localparam kind_t CASE_COMPLEX = 3'd2;
  localparam kind_t CASE_LINEAR  = 3'd3;
  localparam kind_t CASE_NONE    = 3'd4;

  localparam logic [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
  localparam logic [ROOT_W-1:0] ROOT_MIN = {1'b1, {(ROOT_W-1){1'b0}}};

  typedef struct packed {
    kind_t                    kind;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [DISC_W-1:0] disc;
  } item_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DISC_W-1:0] disc;
    logic signed [NUM_W-1:0]  nb;
    logic signed [NUM_W-1:0]  nlin;
    logic signed [DEN_W-1:0]  den;
  } sq_side_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DISC_W-1:0] disc;
  } div_side_t;

  typedef struct packed {
    logic empty;
    logic near_full;
  } q_stat_t;

endpackage

// File: rtl/qrs_front.sv
// Front end: accepts coefficients, forms the discriminant and classifies the item.
module qrs_front import qrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [COEF_W-1:0] coef_a,
  input  logic signed [COEF_W-1:0] coef_b,
  input  logic signed [COEF_W-1:0] coef_c,
  input  q_stat_t                  qstat,
  output logic                     busy,
  output logic                     push,
  output item_t                    push_item
);

  logic                       v0, v1;
  logic signed [COEF_W-1:0]   a0, b0, c0, a1, b1, c1;
  logic signed [2*COEF_W-1:0] pbb, pac;
  logic signed [DISC_W-1:0]   disc;
  kind_t                      kind;

  // leave room for the two beats still in flight here
  assign busy = qstat.near_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a0 <= coef_a;
      b0 <= coef_b;
      c0 <= coef_c;
    end
    pbb <= b0 * b0;
    pac <= a0 * c0;
    a1  <= a0;
    b1  <= b0;
    c1  <= c0;
  end

  always_comb begin
    disc = DISC_W'(pbb) - (DISC_W'(pac) <<< 2);
    if (a1 == '0) begin
      kind = (b1 == '0) ? CASE_NONE : CASE_LINEAR;
    end else if (disc > 0) begin
      kind = CASE_TWO;
    end else if (disc == '0) begin
      kind = CASE_DOUBLE;
    end else begin
      kind = CASE_COMPLEX;
    end
  end

  assign push           = v1;
  assign push_item.kind = kind;
  assign push_item.a    = a1;
  assign push_item.b    = b1;
  assign push_item.c    = c1;
  assign push_item.disc = disc;

endmodule

// File: rtl/qrs_fifo.sv
// Short queue between the front end and the back end.
`include "quadratic_root_solver_assert.svh"
module qrs_fifo import qrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   pop_item,
  output q_stat_t qstat
);

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  assign pop_item        = mem[rd_ptr];
  assign qstat.empty     = (count == '0);
  assign qstat.near_full = (count >= CNT_W'(FIFO_DEPTH - 2));

  `QRS_NEVER(a_no_overrun, push && !pop && count == CNT_W'(FIFO_DEPTH), "queue overrun")
  `QRS_NEVER(a_no_underrun, pop && count == '0, "queue underrun")
  `QRS_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + CNT_W'(1), "count stuck")

endmodule

// File: rtl/qrs_sqrt.sv
// Pipelined floored square root, one result bit per stage.
module qrs_sqrt import qrs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [SQ_IN_W-1:0] x,
  input  sq_side_t           in_side,
  output logic               out_valid,
  output logic [SQ_W-1:0]    root,
  output sq_side_t           out_side
);

  logic               st_v    [SQ_W+1];
  logic [SQ_W+1:0]    st_rem  [SQ_W+1];
  logic [SQ_W-1:0]    st_rt   [SQ_W+1];
  logic [SQ_IN_W-1:0] st_x    [SQ_W+1];
  sq_side_t           st_side [SQ_W+1];

  always_ff @(posedge clk) begin
    if (rst) st_v[0] <= 1'b0;
    else     st_v[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    st_rem[0]  <= '0;
    st_rt[0]   <= '0;
    st_x[0]    <= x;
    st_side[0] <= in_side;
  end

  for (genvar i = 0; i < SQ_W; i++) begin : g_stage
    logic [SQ_W+1:0] rem_sh, trial;
    logic            ge;

    // bring down the next two radicand bits and try the next root bit
    assign rem_sh = {st_rem[i][SQ_W-1:0], st_x[i][SQ_IN_W-1 -: 2]};
    assign trial  = {st_rt[i], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) st_v[i+1] <= 1'b0;
      else     st_v[i+1] <= st_v[i];
    end

    always_ff @(posedge clk) begin
      st_rem[i+1]  <= ge ? rem_sh - trial : rem_sh;
      st_rt[i+1]   <= {st_rt[i][SQ_W-2:0], ge};
      st_x[i+1]    <= st_x[i] << 2;
      st_side[i+1] <= st_side[i];
    end
  end

  assign out_valid = st_v[SQ_W];
  assign root      = st_rt[SQ_W];
  assign out_side  = st_side[SQ_W];

endmodule

// File: rtl/qrs_div.sv
// Pipelined two-lane signed divider sharing one divisor, truncating toward zero.
module qrs_div import qrs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [NUM_W-1:0] n1,
  input  logic signed [NUM_W-1:0] n2,
  input  logic signed [DEN_W-1:0] den,
  input  div_side_t               in_side,
  output logic                    out_valid,
  output logic [QUO_W-1:0]        mag1,
  output logic [QUO_W-1:0]        mag2,
  output logic                    neg1,
  output logic                    neg2,
  output div_side_t               out_side
);

  logic             st_v    [QUO_W+1];
  logic [DVS_W:0]   st_rem  [QUO_W+1][2];
  logic [DVD_W-1:0] st_dvd  [QUO_W+1][2];
  logic [QUO_W-1:0] st_quo  [QUO_W+1][2];
  logic             st_neg  [QUO_W+1][2];
  logic [DVS_W-1:0] st_dvs  [QUO_W+1];
  div_side_t        st_side [QUO_W+1];

  logic [NUM_W-1:0] abs1, abs2;

  assign abs1 = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
  assign abs2 = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);

  always_ff @(posedge clk) begin
    if (rst) st_v[0] <= 1'b0;
    else     st_v[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    st_dvs[0]    <= den[DEN_W-1] ? DVS_W'(-den) : DVS_W'(den);
    st_side[0]   <= in_side;
    st_rem[0][0] <= '0;
    st_rem[0][1] <= '0;
    st_quo[0][0] <= '0;
    st_quo[0][1] <= '0;
    st_dvd[0][0] <= {abs1, FRAC_IN'(0)};
    st_dvd[0][1] <= {abs2, FRAC_IN'(0)};
    st_neg[0][0] <= n1[NUM_W-1] ^ den[DEN_W-1];
    st_neg[0][1] <= n2[NUM_W-1] ^ den[DEN_W-1];
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) st_v[i+1] <= 1'b0;
      else     st_v[i+1] <= st_v[i];
    end

    always_ff @(posedge clk) begin
      st_dvs[i+1]  <= st_dvs[i];
      st_side[i+1] <= st_side[i];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DVS_W:0] rem_sh;
      logic           ge;

      // shift in the next dividend bit, subtract when it fits
      assign rem_sh = {st_rem[i][l][DVS_W-1:0], st_dvd[i][l][DVD_W-1]};
      assign ge     = (rem_sh >= {1'b0, st_dvs[i]});

      always_ff @(posedge clk) begin
        st_rem[i+1][l] <= ge ? rem_sh - {1'b0, st_dvs[i]} : rem_sh;
        st_dvd[i+1][l] <= st_dvd[i][l] << 1;
        st_quo[i+1][l] <= {st_quo[i][l][QUO_W-2:0], ge};
        st_neg[i+1][l] <= st_neg[i][l];
      end
    end
  end

  assign out_valid = st_v[QUO_W];
  assign mag1      = st_quo[QUO_W][0];
  assign mag2      = st_quo[QUO_W][1];
  assign neg1      = st_neg[QUO_W][0];
  assign neg2      = st_neg[QUO_W][1];
  assign out_side  = st_side[QUO_W];

endmodule

// File: rtl/qrs_back.sv
// Back end: square root, numerators, division, saturation and result register.
module qrs_back import qrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  q_stat_t                  qstat,
  input  item_t                    q_item,
  output logic                     pop,
  output logic                     done,
  output logic [2:0]               root_case,
  output logic signed [DISC_W-1:0] discriminant,
  output logic signed [ROOT_W-1:0] real_one,
  output logic signed [ROOT_W-1:0] real_two,
  output logic [ROOT_W-2:0]        imag_part,
  output logic                     overflow
);

  localparam logic [QUO_W-1:0] MIN_MAG = QUO_W'(1) << (ROOT_W - 1);
  localparam logic [QUO_W-1:0] MAX_MAG = MIN_MAG - QUO_W'(1);

  logic [DISC_W-1:0]        dabs;
  logic [SQ_IN_W-1:0]       sq_x;
  sq_side_t                 ent_side;

  logic                     s_valid;
  logic [SQ_W-1:0]          s_root;
  sq_side_t                 s_side;
  logic signed [NUM_W-1:0]  s_ext, n1_c, n2_c;

  logic                     nv;
  logic signed [NUM_W-1:0]  n1, n2;
  logic signed [DEN_W-1:0]  nden;
  div_side_t                nside;

  logic                     d_valid, d_neg1, d_neg2;
  logic [QUO_W-1:0]         d_mag1, d_mag2;
  div_side_t                d_side;

  logic                     o1, o2, oi;
  logic [ROOT_W-1:0]        r1, r2;
  logic [ROOT_W-2:0]        im;

  // back end never stalls: take a beat whenever one waits
  assign pop = !qstat.empty;

  always_comb begin
    dabs          = q_item.disc[DISC_W-1] ? DISC_W'(-q_item.disc) : DISC_W'(q_item.disc);
    sq_x          = SQ_IN_W'({dabs[MAG_W-1:0], FRAC_OUT'(0)});
    ent_side.kind = q_item.kind;
    ent_side.disc = q_item.disc;
    ent_side.nb   = -(NUM_W'(q_item.b) <<< FRAC_IN);
    ent_side.nlin = -(NUM_W'(q_item.c) <<< FRAC_IN);
    ent_side.den  = (q_item.kind == CASE_LINEAR) ? DEN_W'(q_item.b)
                                                  : (DEN_W'(q_item.a) <<< 1);
  end

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop),
    .x         (sq_x),
    .in_side   (ent_side),
    .out_valid (s_valid),
    .root      (s_root),
    .out_side  (s_side)
  );

  assign s_ext = signed'(NUM_W'(s_root));

  always_comb begin
    case (s_side.kind)
      CASE_TWO: begin
        n1_c = s_side.nb - s_ext;
        n2_c = s_side.nb + s_ext;
      end
      CASE_COMPLEX: begin
        n1_c = s_side.nb;
        n2_c = s_ext;
      end
      CASE_LINEAR: begin
        n1_c = s_side.nlin;
        n2_c = s_side.nlin;
      end
      default: begin
        n1_c = s_side.nb;
        n2_c = s_side.nb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) nv <= 1'b0;
    else     nv <= s_valid;
  end

  always_ff @(posedge clk) begin
    n1         <= n1_c;
    n2         <= n2_c;
    nden       <= s_side.den;
    nside.kind <= s_side.kind;
    nside.disc <= s_side.disc;
  end

  qrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nv),
    .n1        (n1),
    .n2        (n2),
    .den       (nden),
    .in_side   (nside),
    .out_valid (d_valid),
    .mag1      (d_mag1),
    .mag2      (d_mag2),
    .neg1      (d_neg1),
    .neg2      (d_neg2),
    .out_side  (d_side)
  );

  always_comb begin
    o1 = d_neg1 ? (d_mag1 > MIN_MAG) : (d_mag1 > MAX_MAG);
    o2 = d_neg2 ? (d_mag2 > MIN_MAG) : (d_mag2 > MAX_MAG);
    oi = (d_mag2 > MAX_MAG);
    if (o1)          r1 = d_neg1 ? ROOT_MIN : ROOT_MAX;
    else if (d_neg1) r1 = ROOT_W'(QUO_W'(-d_mag1));
    else             r1 = ROOT_W'(d_mag1);
    if (o2)          r2 = d_neg2 ? ROOT_MIN : ROOT_MAX;
    else if (d_neg2) r2 = ROOT_W'(QUO_W'(-d_mag2));
    else             r2 = ROOT_W'(d_mag2);
    im = oi ? ROOT_MAX[ROOT_W-2:0] : d_mag2[ROOT_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= d_valid;
  end

  always_ff @(posedge clk) begin
    root_case <= d_side.kind;
    case (d_side.kind)
      CASE_TWO: begin
        discriminant <= d_side.disc;
        real_one     <= r1;
        real_two     <= r2;
        imag_part    <= '0;
        overflow     <= o1 | o2;
      end
      CASE_DOUBLE: begin
        discriminant <= d_side.disc;
        real_one     <= r1;
        real_two     <= r1;
        imag_part    <= '0;
        overflow     <= o1;
      end
      CASE_COMPLEX: begin
        discriminant <= d_side.disc;
        real_one     <= r1;
        real_two     <= r1;
        imag_part    <= im;
        overflow     <= o1 | oi;
      end
      CASE_LINEAR: begin
        discriminant <= '0;
        real_one     <= r1;
        real_two     <= r1;
        imag_part    <= '0;
        overflow     <= o1;
      end
      default: begin
        discriminant <= '0;
        real_one     <= '0;
        real_two     <= '0;
        imag_part    <= '0;
        overflow     <= 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/quadratic_root_solver.sv
// Quadratic root solver top level: front end, queue and back end.
//
// Usage:
//   Drive coef_a, coef_b, coef_c (signed Q8.8) with start high; the set is
//   taken at the rising edge where start is high and busy is low.
//   One result per set appears for exactly one cycle with done high:
//   root_case, discriminant (Q20.16), real_one, real_two (Q16.16, roots
//   saturated), imag_part (unsigned Q15.16, saturated) and overflow.
// Throughput: one coefficient set per cycle, sustained.
// Sets pass through the front-end registers, the queue, the square root
//   pipeline (one bit per stage), the numerator register, the divider
//   pipeline (one bit per stage) and the result register.
// Results leave in the order sets were taken. The receiver cannot stall the
//   block, so the back end drains the queue every cycle and busy stays low in
//   normal use; it rises only to protect the queue.
// Reset (rst, synchronous, active high) empties the queue and drops all work
//   in flight; no done pulse follows until a new set is taken.
`include "quadratic_root_solver_assert.svh"
module quadratic_root_solver import qrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [COEF_W-1:0] coef_a,
  input  logic signed [COEF_W-1:0] coef_b,
  input  logic signed [COEF_W-1:0] coef_c,
  output logic                     done,
  output logic [2:0]               root_case,
  output logic signed [DISC_W-1:0] discriminant,
  output logic signed [ROOT_W-1:0] real_one,
  output logic signed [ROOT_W-1:0] real_two,
  output logic [ROOT_W-2:0]        imag_part,
  output logic                     overflow
);

  q_stat_t qstat;
  logic    push, pop;
  item_t   push_item, pop_item;

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .coef_a    (coef_a),
    .coef_b    (coef_b),
    .coef_c    (coef_c),
    .qstat     (qstat),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  qrs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  qrs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .q_item       (pop_item),
    .pop          (pop),
    .done         (done),
    .root_case    (root_case),
    .discriminant (discriminant),
    .real_one     (real_one),
    .real_two     (real_two),
    .imag_part    (imag_part),
    .overflow     (overflow)
  );

  `QRS_ASSERT_SAME(a_none_zero, done && root_case == CASE_NONE, real_one == '0 && !overflow, "no-root result not cleared")
  `QRS_ASSERT_SAME(a_imag_only_complex, done && root_case != CASE_COMPLEX, imag_part == '0, "imaginary part outside complex case")

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the quadratic root solver.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  typedef struct {
    kind_t                    kind;
    logic signed [DISC_W-1:0] disc;
    logic signed [ROOT_W-1:0] r1;
    logic signed [ROOT_W-1:0] r2;
    logic [ROOT_W-2:0]        im;
    logic                     ovf;
  } roots_t;

  localparam longint RMAX = 64'sd2147483647;
  localparam longint RMIN = -64'sd2147483648;
  localparam int LATENCY = 66;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COEF_W-1:0] coef_a = '0;
  logic signed [COEF_W-1:0] coef_b = '0;
  logic signed [COEF_W-1:0] coef_c = '0;
  logic done;
  logic [2:0] root_case;
  logic signed [DISC_W-1:0] discriminant;
  logic signed [ROOT_W-1:0] real_one;
  logic signed [ROOT_W-1:0] real_two;
  logic [ROOT_W-2:0] imag_part;
  logic overflow;

  roots_t pending_roots[$];
  int errors = 0;

  quadratic_root_solver dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_root(longint v, ref logic ovf);
    if (v > RMAX) begin
      ovf = 1'b1;
      return RMAX;
    end
    if (v < RMIN) begin
      ovf = 1'b1;
      return RMIN;
    end
    return v;
  endfunction

  function automatic roots_t solve_roots(logic signed [COEF_W-1:0] ca,
                                         logic signed [COEF_W-1:0] cb,
                                         logic signed [COEF_W-1:0] cc);
    longint a, b, c, d, den, nb, s, q, r1, r2, im;
    logic ovf;
    roots_t r;
    a = ca; b = cb; c = cc;
    d = 0; r1 = 0; r2 = 0; im = 0; ovf = 1'b0;
    if (a == 0) begin
      if (b != 0) begin
        r.kind = CASE_LINEAR;
        r1 = clamp_root((-c * 65536) / b, ovf);
        r2 = r1;
      end else begin
        r.kind = CASE_NONE;
      end
    end else begin
      den = 2 * a;
      nb = -b * 256;
      d = b * b - 4 * a * c;
      if (d > 0) begin
        s = longint'(floor_sqrt(longint'(d) << 16));
        r.kind = CASE_TWO;
        r1 = clamp_root(((nb - s) * 256) / den, ovf);
        r2 = clamp_root(((nb + s) * 256) / den, ovf);
      end else if (d == 0) begin
        r.kind = CASE_DOUBLE;
        r1 = clamp_root((nb * 256) / den, ovf);
        r2 = r1;
      end else begin
        s = longint'(floor_sqrt(longint'(-d) << 16));
        q = (s * 256) / den;
        r.kind = CASE_COMPLEX;
        r1 = clamp_root((nb * 256) / den, ovf);
        r2 = r1;
        if (q < 0) q = -q;
        if (q > RMAX) begin
          q = RMAX;
          ovf = 1'b1;
        end
        im = q;
      end
    end
    r.disc = d[DISC_W-1:0];
    r.r1 = r1[ROOT_W-1:0];
    r.r2 = r2[ROOT_W-1:0];
    r.im = im[ROOT_W-2:0];
    r.ovf = ovf;
    return r;
  endfunction

  // Drive one coefficient set and hold it until taken.
  task automatic send_coefs(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                            logic [COEF_W-1:0] c, int idle_pct);
    int gap;
    start <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    do @(posedge clk); while (busy);
    pending_roots.push_back(solve_roots(a, b, c));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    roots_t e;
    if (!rst && done) begin
      if (pending_roots.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        e = pending_roots.pop_front();
        if (root_case !== e.kind) begin
          $error("root_case exp %0d got %0d", e.kind, root_case); errors++;
        end
        if (discriminant !== e.disc) begin
          $error("discriminant exp %0d got %0d", e.disc, discriminant); errors++;
        end
        if (real_one !== e.r1) begin
          $error("real_one exp %0d got %0d", e.r1, real_one); errors++;
        end
        if (real_two !== e.r2) begin
          $error("real_two exp %0d got %0d", e.r2, real_two); errors++;
        end
        if (imag_part !== e.im) begin
          $error("imag_part exp %0d got %0d", e.im, imag_part); errors++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, overflow); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_coefs(16'h0000, 16'h0000, 16'h1234, 0);  // no root
    send_coefs(16'h0000, 16'h0000, 16'h0000, 0);
    send_coefs(16'h0000, 16'h0100, 16'h0200, 0);  // linear
    send_coefs(16'h0000, 16'h0001, 16'h8000, 0);  // linear, saturates high
    send_coefs(16'h0000, 16'h0001, 16'h7fff, 0);  // linear, large negative root
    send_coefs(16'h0000, 16'h8000, 16'h8000, 0);
    send_coefs(16'h0100, 16'h0200, 16'h0100, 0);  // double root
    send_coefs(16'h0100, 16'h0000, 16'h0000, 0);
    send_coefs(16'h0100, 16'h0000, 16'hff00, 0);  // two real
    send_coefs(16'h0100, 16'h0000, 16'h0100, 0);  // complex
    send_coefs(16'h0001, 16'h7fff, 16'h0000, 0);  // two real, one large negative root
    send_coefs(16'h0001, 16'h0000, 16'h7fff, 0);  // complex, large imaginary part
    send_coefs(16'hffff, 16'h0000, 16'h8000, 0);
    send_coefs(16'h8000, 16'h8000, 16'h8000, 0);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff, 0);
    send_coefs(16'h7fff, 16'h8000, 16'h8000, 0);
    send_coefs(16'hffff, 16'hffff, 16'hffff, 0);
    send_coefs(16'h0001, 16'h0001, 16'h0001, 0);
  endtask

  task automatic test_random(int count, int idle_pct);
    int r, s, sg;
    logic [COEF_W-1:0] a, b, c;
    repeat (count) begin
      a = COEF_W'($urandom);
      b = COEF_W'($urandom);
      c = COEF_W'($urandom);
      case ($urandom_range(9))
        0: a = '0;
        1: begin
          a = '0;
          if ($urandom_range(1)) b = '0;
        end
        2, 3: begin
          // perfect square: b*b == 4ac
          r = $urandom_range(0, 127);
          s = $urandom_range(1, 127);
          sg = $urandom_range(1) ? -1 : 1;
          if (r == 0) r = 1;
          a = COEF_W'(sg * r * r);
          c = COEF_W'(sg * s * s);
          b = COEF_W'(($urandom_range(1) ? -2 : 2) * r * s);
        end
        4: begin
          a = COEF_W'($signed(16'($urandom_range(0, 15))) - 8);
          if (a == 0) a = 1;
        end
        default: ;
      endcase
      send_coefs(a, b, c, idle_pct);
    end
  endtask

  // Hold off until the pipeline has emptied, then send one more set.
  task automatic test_drain();
    start <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    send_coefs(16'h0200, 16'hfc00, 16'h0100, 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600, 0);
    test_drain();
    test_random(450, 67);
    test_random(450, 36);
    test_random(350, 0);
    start <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
